### rtl/unique_entry_fifo_macros.svh
// ----------------------------------------------------------------------------
// unique_entry_fifo assertion macros
// Shared property wrappers for the unique entry FIFO checks.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_ENTRY_FIFO_MACROS_SVH
`define UNIQUE_ENTRY_FIFO_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define UEF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define UEF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ufifo_pkg.sv
// ----------------------------------------------------------------------------
// ufifo_pkg
// Types, sizes and helpers shared by the unique entry FIFO modules.
// ----------------------------------------------------------------------------
package ufifo_pkg;

    localparam int DEPTH = 16;
    localparam int ID_W  = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        FN_ENQ  = 2'd0,
        FN_DEQ  = 2'd1,
        FN_LIST = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEQ,
        S_LIST,
        S_EMPTY
    } t_state;

    // which result word the datapath builds this cycle
    typedef enum logic [2:0] {
        EM_NONE,
        EM_ENQ,
        EM_DEQ,
        EM_LIST,
        EM_EMPTY
    } t_emit;

    typedef struct packed {
        logic  start;   // word accepted: latch id, read head
        logic  step;    // compare current entry, read next
        t_emit emit;    // load output register
    } t_cmd;

    typedef struct packed {
        logic occ_zero;
        logic scan_done;  // every occupied entry compared
        logic list_last;  // current entry is the tail entry
    } t_dp_sts;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

### rtl/ufifo_ctrl.sv
// ----------------------------------------------------------------------------
// ufifo_ctrl
// Sequencer for enqueue scan, dequeue and list; owns the output valid.
// ----------------------------------------------------------------------------
module ufifo_ctrl
    import ufifo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [1:0]  i_func,
    input  logic        i_out_stall,
    input  t_dp_sts     i_sts,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_cmd        o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   in_acc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '{start: 1'b0, step: 1'b0, emit: EM_NONE};
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.start = 1'b1;
                    case (t_func'(i_func))
                        FN_ENQ:  n_state = S_SCAN;
                        FN_DEQ:  n_state = i_sts.occ_zero ? S_EMPTY : S_DEQ;
                        FN_LIST: n_state = i_sts.occ_zero ? S_EMPTY : S_LIST;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (!i_sts.scan_done) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.emit = EM_ENQ;
                    n_state    = S_IDLE;
                end
            end
            S_DEQ: begin
                if (out_free) begin
                    o_cmd.emit = EM_DEQ;
                    n_state    = S_IDLE;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    o_cmd.emit = EM_LIST;
                    if (i_sts.list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    o_cmd.emit = EM_EMPTY;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit != EM_NONE) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/ufifo_dp.sv
// ----------------------------------------------------------------------------
// ufifo_dp
// Entry memory, pointers, occupancy, scan compare and output word register.
// ----------------------------------------------------------------------------
`include "unique_entry_fifo_macros.svh"

module ufifo_dp
    import ufifo_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [ID_W-1:0] i_entry_id,
    input  t_cmd            i_cmd,
    output t_dp_sts         o_sts,
    output logic [1:0]      o_status,
    output logic [ID_W-1:0] o_out_id,
    output logic            o_last
);

    logic [ID_W-1:0]  mem [DEPTH];
    logic [ID_W-1:0]  r_rd_data;

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_occ, n_occ;

    logic [PTR_W-1:0] r_scan_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_dup;
    logic [ID_W-1:0]  r_id;

    t_status          r_status, n_status;
    logic [ID_W-1:0]  r_out_id, n_out_id;
    logic             r_last, n_last;

    logic [PTR_W-1:0] rd_addr;
    logic             rd_en;
    logic             wr_en;
    logic             match;
    logic             full;
    logic             enq_ok;
    logic             list_last;

    assign rd_addr   = i_cmd.start ? r_head : r_scan_ptr;
    assign rd_en     = i_cmd.start || i_cmd.step;
    assign match     = (r_rd_data == r_id);
    assign full      = (r_occ == CNT_W'(DEPTH));
    assign enq_ok    = !r_dup && !full;
    assign list_last = ((r_cnt + CNT_W'(1)) == r_occ);
    assign wr_en     = (i_cmd.emit == EM_ENQ) && enq_ok;

    assign o_sts = '{occ_zero:  (r_occ == '0),
                     scan_done: (r_cnt == r_occ),
                     list_last: list_last};

    // entry storage, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= r_id;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_id       <= i_entry_id;
            r_scan_ptr <= wrap_next(r_head);
            r_cnt      <= '0;
            r_dup      <= 1'b0;
        end else if (i_cmd.step) begin
            r_scan_ptr <= wrap_next(r_scan_ptr);
            r_cnt      <= r_cnt + CNT_W'(1);
            r_dup      <= r_dup || match;
        end
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_occ    = r_occ;
        n_status = r_status;
        n_out_id = r_out_id;
        n_last   = r_last;
        case (i_cmd.emit)
            EM_ENQ: begin
                n_out_id = '0;
                n_last   = 1'b1;
                if (r_dup) begin
                    n_status = ST_DUP;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_tail   = wrap_next(r_tail);
                    n_occ    = r_occ + CNT_W'(1);
                end
            end
            EM_DEQ: begin
                n_status = ST_OK;
                n_out_id = r_rd_data;
                n_last   = 1'b1;
                n_head   = wrap_next(r_head);
                n_occ    = r_occ - CNT_W'(1);
            end
            EM_LIST: begin
                n_status = ST_OK;
                n_out_id = r_rd_data;
                n_last   = list_last;
            end
            EM_EMPTY: begin
                n_status = ST_EMPTY;
                n_out_id = '0;
                n_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_out_id <= n_out_id;
        r_last   <= n_last;
    end

    assign o_status = r_status;
    assign o_out_id = r_out_id;
    assign o_last   = r_last;

    `UEF_ASSERT_NOW(a_deq_nonempty, i_clk, i_rst_n, i_cmd.emit == EM_DEQ, r_occ != '0, "dequeue with empty queue")
    `UEF_ASSERT_NOW(a_list_in_range, i_clk, i_rst_n, i_cmd.emit == EM_LIST, r_cnt < r_occ, "list word beyond occupancy")
    `UEF_ASSERT_NOW(a_step_in_range, i_clk, i_rst_n, i_cmd.step, r_cnt < r_occ, "scan step past last entry")
    `UEF_ASSERT_NEXT(a_enq_grows, i_clk, i_rst_n, wr_en, r_occ == $past(r_occ) + CNT_W'(1), "enqueue did not grow occupancy")

endmodule

### rtl/unique_entry_fifo.sv
// ----------------------------------------------------------------------------
// unique_entry_fifo
// FIFO of 16-bit identifiers that rejects an identifier already queued.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall, i_func, i_entry_id): one word is
//   an operation. func 0 enqueue, 1 dequeue, 2 list; func 3 is dropped.
//   Output channel (o_out_valid / i_out_stall, o_status, o_out_id, o_last):
//   enqueue and dequeue give one word, list gives one word per queued entry
//   from head to tail, o_last set on the final one. Empty queue: one word,
//   status empty.
//   Flow: one item is in flight at a time; o_in_stall rises after the
//   accept and holds until its last word is loaded into the output register.
//   Enqueue first compares the id with each stored entry in turn through
//   the single memory read port (the duplicate compare); list reads one
//   entry per word, head to tail; dequeue and empty replies need no scan.
//   A finished word sits in the output register while the next operation
//   is taken; a stalled receiver holds the word and pauses the sequencer.
//   Reset (synchronous, active low) empties the queue and the output; the
//   entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module unique_entry_fifo
    import ufifo_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [1:0]      i_func,
    input  logic [ID_W-1:0] i_entry_id,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [1:0]      o_status,
    output logic [ID_W-1:0] o_out_id,
    output logic            o_last
);

    // command / status between sequencer and datapath
    t_cmd    cmd;
    t_dp_sts dp_sts;

    ufifo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // memory, pointers, compare and output word register
    ufifo_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry_id (i_entry_id),
        .i_cmd      (cmd),
        .o_sts      (dp_sts),
        .o_status   (o_status),
        .o_out_id   (o_out_id),
        .o_last     (o_last)
    );

endmodule

### sim/tb_unique_entry_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unique_entry_fifo
// Self-checking bench for the duplicate-rejecting identifier FIFO. A model
// queue in the bench predicts every reply word, and a monitor compares the
// words the block returns against those predictions in order. Traffic
// includes corner cases, a fill to full under a long output hold, and random
// operations under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_unique_entry_fifo;
    import ufifo_pkg::*;

    // func 3 has no meaning; the block drops it without a reply
    localparam logic [1:0] FN_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 100000;
    localparam int         HOLD_CYCLES = 80;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] id;
        logic            last;
    } reply_t;

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            i_in_valid = 1'b0;
    logic [1:0]      i_func     = FN_ENQ;
    logic [ID_W-1:0] i_entry_id = '0;
    logic            i_out_stall = 1'b0;
    logic            o_in_stall;
    logic            o_out_valid;
    logic [1:0]      o_status;
    logic [ID_W-1:0] o_out_id;
    logic            o_last;

    // model of the queue contents, head at index 0
    logic [ID_W-1:0] queued_ids[$];
    // reply words predicted but not yet returned, oldest first
    reply_t          pending_replies[$];

    int mismatches    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_request  = 0;   // set by a test, consumed by the stall process
    int hold_left     = 0;

    unique_entry_fifo DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_entry_id  (i_entry_id),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_last      (o_last)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // queue model
    // ------------------------------------------------------------------
    function automatic bit holds_id(input logic [ID_W-1:0] id);
        foreach (queued_ids[k]) begin
            if (queued_ids[k] == id) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] id;
        do id = ID_W'($urandom); while (holds_id(id));
        return id;
    endfunction

    // Update the model for one accepted word and queue the replies it causes.
    // The duplicate check wins over the full check.
    function automatic void predict_replies(input logic [1:0] func,
                                            input logic [ID_W-1:0] id);
        case (func)
            FN_ENQ: begin
                if (holds_id(id)) begin
                    pending_replies.push_back('{ST_DUP, '0, 1'b1});
                end else if (queued_ids.size() >= DEPTH) begin
                    pending_replies.push_back('{ST_FULL, '0, 1'b1});
                end else begin
                    queued_ids.push_back(id);
                    pending_replies.push_back('{ST_OK, '0, 1'b1});
                end
            end
            FN_DEQ: begin
                if (queued_ids.size() == 0) begin
                    pending_replies.push_back('{ST_EMPTY, '0, 1'b1});
                end else begin
                    pending_replies.push_back('{ST_OK, queued_ids.pop_front(), 1'b1});
                end
            end
            FN_LIST: begin
                if (queued_ids.size() == 0) begin
                    pending_replies.push_back('{ST_EMPTY, '0, 1'b1});
                end else begin
                    foreach (queued_ids[k]) begin
                        pending_replies.push_back('{ST_OK, queued_ids[k],
                                                    k == queued_ids.size() - 1});
                    end
                end
            end
            default: ;  // dropped, no reply
        endcase
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // Offer one word, with random idle cycles first. Valid stays high on
    // return so back-to-back words never drop and re-raise it in one step.
    task automatic send_word(input logic [1:0] func, input logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_entry_id <= id;
        do @(posedge i_clk); while (o_in_stall);
        predict_replies(func, id);
    endtask

    // Stop offering and wait for every outstanding reply.
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // output side: stall generation and reply checking
    // ------------------------------------------------------------------
    // A hold request stalls the output for a fixed stretch, otherwise the
    // stall is a per-cycle coin flip at the current rate.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        reply_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected word: expected none, got status=%0d id=%h last=%b",
                         $time, o_status, o_out_id, o_last);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, o_status);
                    mismatches++;
                end
                if (o_out_id !== want.id) begin
                    $display("%0t: id mismatch: expected %h, got %h",
                             $time, want.id, o_out_id);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch: expected %b, got %b",
                             $time, want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // Empty replies, identifier extremes, duplicates at head and tail,
    // dropped func 3, and re-enqueue of an id after it has left the queue.
    task automatic test_corners();
        send_idle_pct = 0;
        out_stall_pct = 0;
        send_word(FN_DEQ,    16'hFFFF);
        send_word(FN_LIST,   16'h0000);
        send_word(FN_ENQ,    16'h0000);
        send_word(FN_ENQ,    16'hFFFF);
        send_word(FN_ENQ,    16'h0000);
        send_word(FN_ENQ,    16'hFFFF);
        send_word(FN_UNUSED, 16'hFFFF);
        send_word(FN_LIST,   16'hFFFF);
        send_word(FN_DEQ,    16'h0000);
        send_word(FN_ENQ,    16'h0000);
        send_word(FN_UNUSED, 16'h0000);
        send_word(FN_LIST,   16'h5A5A);
        send_word(FN_DEQ,    16'hA5A5);
        send_word(FN_DEQ,    16'h0000);
        send_word(FN_DEQ,    16'hFFFF);
        send_word(FN_LIST,   16'hFFFF);
        drain_replies();
    endtask

    // Fill to full while the output is held, so the block backs up and stalls
    // its input. Then full and duplicate-while-full rejects, a full-length
    // list, and a run of dequeues and enqueues with a final list.
    task automatic test_fill_under_backpressure();
        send_idle_pct = 0;
        out_stall_pct = 0;
        hold_request  = HOLD_CYCLES;
        while (queued_ids.size() < DEPTH) begin
            send_word(FN_ENQ, fresh_id());
        end
        send_word(FN_ENQ, fresh_id());
        send_word(FN_ENQ, queued_ids[DEPTH-1]);
        send_word(FN_LIST, 16'hFFFF);
        drain_replies();
        repeat (5) send_word(FN_DEQ, ID_W'($urandom));
        repeat (5) send_word(FN_ENQ, fresh_id());
        send_word(FN_LIST, 16'h0000);
        drain_replies();
    endtask

    // Random mix. Enqueues outnumber dequeues so the queue keeps reaching
    // full; a quarter of enqueues reuse a queued id to hit the duplicate path.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        int              counted;
        int              roll;
        logic [1:0]      func;
        logic [ID_W-1:0] id;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        counted       = 0;
        while (counted < n_items) begin
            roll = $urandom_range(99);
            id   = ID_W'($urandom);
            if (roll < 50) begin
                func = FN_ENQ;
                if ($urandom_range(3) == 0 && queued_ids.size() != 0) begin
                    id = queued_ids[$urandom_range(queued_ids.size() - 1)];
                end else if ($urandom_range(19) == 0) begin
                    id = $urandom_range(1) ? '1 : '0;
                end
            end else if (roll < 77) begin
                func = FN_DEQ;
            end else if (roll < 95) begin
                func = FN_LIST;
            end else begin
                func = FN_UNUSED;
            end
            send_word(func, id);
            if (func != FN_UNUSED) begin
                counted++;
            end
        end
        drain_replies();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_fill_under_backpressure();
        test_random_traffic(0,  0,  20);
        test_random_traffic(52, 0,  20);
        test_random_traffic(0,  52, 20);
        test_random_traffic(8,  8,  20);

        drain_replies();
        // catch stray words after the last expected one
        repeat (DEPTH + 4) @(posedge i_clk);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/ufifo_pkg.sv
rtl/ufifo_ctrl.sv
rtl/ufifo_dp.sv
rtl/unique_entry_fifo.sv
sim/tb_unique_entry_fifo.sv
